// ===== rtl/esph_pkg.sv =====
// shared types, codes and constants of the encoder speed, position and homing block
`default_nettype none

package esph_pkg;

    // field widths
    localparam int POS_W   = 32;
    localparam int ANGLE_W = 48;
    localparam int SPEED_W = 41;
    localparam int CPR_W   = 16;
    localparam int SPS_W   = 10;
    localparam int TMO_W   = 32;
    localparam int IN_W    = 16;

    localparam int COUNTER_BITS_DEF = 16;

    // scaling lanes: product = magnitude * small factor, then << Q_SHIFT, then / cpr
    // angle: 360 * 256 = 90 << 10, speed: sps * 60 * 256 = (sps * 15) << 10
    localparam int MUL_W         = 14;
    localparam int Q_SHIFT       = 10;
    localparam int ANGLE_FACTOR  = 90;
    localparam int SPEED_FACTOR  = 15;
    localparam int FACTOR_SHIFT  = 4;

    // configuration
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CPR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [CPR_W-1:0] CPR_RESET = 16'd4096;
    localparam logic [SPS_W-1:0] SPS_RESET = 10'd10;
    localparam logic [TMO_W-1:0] TMO_RESET = 32'd10000;

    // motor commands
    localparam logic [1:0] MOTOR_NONE    = 2'd0;
    localparam logic [1:0] MOTOR_REVERSE = 2'd1;
    localparam logic [1:0] MOTOR_HALT    = 2'd2;

    // direction codes, two bit signed
    localparam logic [1:0] DIR_STILL = 2'b00;
    localparam logic [1:0] DIR_FWD   = 2'b01;
    localparam logic [1:0] DIR_REV   = 2'b11;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_START  = 2'd1,
        KIND_HOME   = 2'd2,
        KIND_TICK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_RUNNING = 2'd1,
        PH_SUCCESS = 2'd2,
        PH_TIMEOUT = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV,
        SC_FIN
    } scale_state_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_CALC,
        TS_PUT
    } top_state_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] motor;
        logic       clear;
    } homing_stat_t;

endpackage

`default_nettype wire

// ===== rtl/esph_scale.sv =====
// one scaling lane: bit-serial multiply, then bit-serial restoring divide, then sign and clamp
`default_nettype none

module esph_scale import esph_pkg::*; #(
    parameter int A_W   = POS_W,
    parameter int B_W   = MUL_W,
    parameter int SHIFT = Q_SHIFT,
    parameter int DIV_W = CPR_W,
    parameter int OUT_W = ANGLE_W
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [A_W-1:0]          a_mag,
    input  wire logic [B_W-1:0]          b,
    input  wire logic                    neg,
    input  wire logic [DIV_W-1:0]        divisor,
    output logic                         done,
    output logic signed [OUT_W-1:0]      result
);

    localparam int P_W   = A_W + B_W;
    localparam int NUM_W = P_W + SHIFT;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int HI_W  = NUM_W - OUT_W + 1;

    scale_state_t state_reg, state_next;

    logic [A_W-1:0]   a_reg;
    logic [P_W-1:0]   prod_reg;
    logic [P_W-1:0]   prod_next;
    logic [A_W:0]     part_sum;
    logic [NUM_W-1:0] num_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W:0]   rem_sh;
    logic             q_bit;
    logic [DIV_W-1:0] divisor_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [HI_W-1:0]  q_hi;
    logic             pos_ovf;
    logic             neg_ovf;
    logic [OUT_W-1:0] mag;

    // shift-add multiply, multiplier held in the low bits of the product
    assign part_sum  = {1'b0, prod_reg[P_W-1:B_W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
    assign prod_next = {part_sum, prod_reg[B_W-1:1]};

    // restoring divide step, quotient bits shift in behind the numerator
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign q_bit    = rem_sh >= {1'b0, divisor_reg};
    assign rem_next = q_bit ? DIV_W'(rem_sh - {1'b0, divisor_reg}) : rem_sh[DIV_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    state_next = SC_MUL;
                end
            end
            SC_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = SC_DIV;
                end
            end
            SC_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = SC_FIN;
                end
            end
            SC_FIN:
            begin
                state_next = SC_IDLE;
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                SC_IDLE:
                begin
                    cnt_reg <= CNT_W'(B_W - 1);
                end
                SC_MUL:
                begin
                    cnt_reg <= (cnt_reg == '0) ? CNT_W'(NUM_W - 1) : cnt_reg - 1'b1;
                end
                SC_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    a_reg       <= a_mag;
                    prod_reg    <= {{A_W{1'b0}}, b};
                    neg_reg     <= neg;
                    divisor_reg <= divisor;
                end
            end
            SC_MUL:
            begin
                prod_reg <= prod_next;
                if (cnt_reg == '0)
                begin
                    num_reg <= {prod_next, {SHIFT{1'b0}}};
                    rem_reg <= '0;
                end
            end
            SC_DIV:
            begin
                num_reg <= {num_reg[NUM_W-2:0], q_bit};
                rem_reg <= rem_next;
            end
            default:
            begin
                num_reg <= num_reg;
            end
        endcase
    end

    // clamp to the signed output range, quotient magnitude is truncated toward zero
    assign q_hi    = num_reg[NUM_W-1:OUT_W-1];
    assign mag     = num_reg[OUT_W-1:0];
    assign pos_ovf = |q_hi;
    assign neg_ovf = (q_hi > HI_W'(1)) || ((q_hi == HI_W'(1)) && (|num_reg[OUT_W-2:0]));

    always_comb
    begin
        done = (state_reg == SC_FIN);
        if (neg_reg)
        begin
            result = neg_ovf ? signed'({1'b1, {(OUT_W-1){1'b0}}}) : signed'(OUT_W'(-mag));
        end
        else
        begin
            result = pos_ovf ? signed'({1'b0, {(OUT_W-1){1'b1}}}) : signed'(mag);
        end
    end

    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == SC_DIV))
        else $error("scale lane finished without a divide pass");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SC_DIV) |-> (rem_reg < divisor_reg))
        else $error("divide remainder not below divisor");

endmodule

`default_nettype wire

// ===== rtl/esph_homing.sv =====
// homing sequencer: start, home switch and millisecond timeout handling
`default_nettype none

module esph_homing import esph_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              evt_valid,
    input  wire kind_t             kind,
    input  wire logic [TMO_W-1:0]  limit_ms,
    output homing_stat_t           stat
);

    phase_t             phase_reg, phase_next;
    logic [TMO_W-1:0]   elapsed_reg, elapsed_next;
    logic [TMO_W-1:0]   elapsed_inc;
    logic               over_time;

    // elapsed time saturates at all ones
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign over_time   = elapsed_inc > limit_ms;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE, PH_SUCCESS:
            begin
                if (evt_valid && kind == KIND_START)
                begin
                    phase_next = PH_RUNNING;
                end
            end
            PH_RUNNING:
            begin
                if (evt_valid && kind == KIND_HOME)
                begin
                    phase_next = PH_SUCCESS;
                end
                else if (evt_valid && kind == KIND_TICK && over_time)
                begin
                    phase_next = PH_TIMEOUT;
                end
            end
            PH_TIMEOUT:
            begin
                phase_next = PH_TIMEOUT;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stat.phase   = phase_reg;
        stat.motor   = MOTOR_NONE;
        stat.clear   = 1'b0;
        elapsed_next = elapsed_reg;
        case (phase_reg)
            PH_IDLE, PH_SUCCESS:
            begin
                if (evt_valid && kind == KIND_START)
                begin
                    stat.motor   = MOTOR_REVERSE;
                    elapsed_next = '0;
                end
            end
            PH_RUNNING:
            begin
                if (evt_valid && kind == KIND_HOME)
                begin
                    stat.motor = MOTOR_HALT;
                    stat.clear = 1'b1;
                end
                else if (evt_valid && kind == KIND_TICK)
                begin
                    elapsed_next = elapsed_inc;
                    if (over_time)
                    begin
                        stat.motor = MOTOR_HALT;
                    end
                end
            end
            default:
            begin
                stat.motor = MOTOR_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
        end
    end

    a_reverse_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && stat.motor == MOTOR_REVERSE) |=> (phase_reg == PH_RUNNING))
        else $error("reverse drive issued without entering running");

    a_timeout_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TIMEOUT) |=> (phase_reg == PH_TIMEOUT))
        else $error("timeout left before reset");

endmodule

`default_nettype wire

// ===== rtl/encoder_speed_position_homing.sv =====
// top level: sample delta, position, direction, angle and speed scaling, homing, result register
//
// channel  side    handshake             beat
// in       sink    in_valid / in_stall   kind, counter_value
// out      source  out_valid / out_stall position, angle_q8, direction, speed_q8,
//                                        homing_status, motor_command, counter_clear
// cfg      sink    cfg_valid / cfg_ready cfg_index, cfg_data
//
// a counter sample beat gets its result from two scaling lanes that run side by side,
// each a bit-serial multiply by the 14-bit factor and a 56-step restoring divide by counts_per_rev
// start, home switch and tick beats skip the scaling lanes and go straight to the put state
// rst_n asynchronously clears control and tracking state and loads the register reset values
// a new input beat is taken while the previous result waits in the output register
// a stalled output holds its beat, the next result waits in staging until the slot frees
`default_nettype none

module encoder_speed_position_homing import esph_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               kind,
    input  wire logic [IN_W-1:0]          counter_value,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [POS_W-1:0]       position,
    output logic signed [ANGLE_W-1:0]     angle_q8,
    output logic signed [1:0]             direction,
    output logic signed [SPEED_W-1:0]     speed_q8,
    output logic [1:0]                    homing_status,
    output logic [1:0]                    motor_command,
    output logic                          counter_clear,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

    top_state_t state_reg, state_next;

    logic [CPR_W-1:0] cpr_reg;
    logic [SPS_W-1:0] sps_reg;
    logic [TMO_W-1:0] tmo_reg;

    logic [COUNTER_BITS-1:0]  prev_count_reg;
    logic [POS_W-1:0]         position_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic [1:0]               dir_reg;
    logic [1:0]               motor_stage_reg;
    logic                     clear_stage_reg;

    logic                     out_valid_reg;
    logic signed [POS_W-1:0]  pos_out_reg;
    logic signed [ANGLE_W-1:0] angle_out_reg;
    logic [1:0]               dir_out_reg;
    logic signed [SPEED_W-1:0] speed_out_reg;
    logic [1:0]               phase_out_reg;
    logic [1:0]               motor_out_reg;
    logic                     clear_out_reg;

    logic in_fire;
    logic sample_fire;
    logic put_fire;
    logic lane_start;

    logic [COUNTER_BITS+IN_W-1:0] raw_ext;
    logic [COUNTER_BITS-1:0]      now_count;
    logic [COUNTER_BITS-1:0]      diff;
    logic [COUNTER_BITS-1:0]      diff_mag;
    logic                         delta_neg;
    logic [POS_W-1:0]             pos_new;
    logic [POS_W-1:0]             pos_mag;
    logic [SPS_W+FACTOR_SHIFT-1:0] sps_ext;
    logic [MUL_W-1:0]             speed_factor;
    logic [CPR_W-1:0]             div_cpr;

    homing_stat_t hstat;

    logic                      angle_done;
    logic                      speed_done;
    logic signed [ANGLE_W-1:0] angle_res;
    logic signed [SPEED_W-1:0] speed_res;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg <= CPR_RESET;
            sps_reg <= SPS_RESET;
            tmo_reg <= TMO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CPR:     cpr_reg <= cfg_data[CPR_W-1:0];
                CFG_SPS:     sps_reg <= cfg_data[SPS_W-1:0];
                CFG_TIMEOUT: tmo_reg <= cfg_data[TMO_W-1:0];
                default:     cpr_reg <= cpr_reg;
            endcase
        end
    end

    // sample delta, wraps at the counter width
    assign raw_ext   = {{COUNTER_BITS{1'b0}}, counter_value};
    assign now_count = raw_ext[COUNTER_BITS-1:0];
    assign diff      = now_count - prev_count_reg;
    assign delta_neg = diff[COUNTER_BITS-1];
    assign diff_mag  = delta_neg ? COUNTER_BITS'(-diff) : diff;
    assign pos_new   = position_reg + POS_W'(signed'(diff));
    assign pos_mag   = pos_new[POS_W-1] ? POS_W'(-pos_new) : pos_new;

    // sps * 15 as a shift and subtract
    assign sps_ext      = {{FACTOR_SHIFT{1'b0}}, sps_reg};
    assign speed_factor = MUL_W'((sps_ext << FACTOR_SHIFT) - sps_ext);
    assign div_cpr      = (cpr_reg == '0) ? CPR_W'(1) : cpr_reg;

    assign in_fire     = in_valid && !in_stall;
    assign sample_fire = in_fire && (kind == KIND_SAMPLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TS_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (kind == KIND_SAMPLE) ? TS_CALC : TS_PUT;
                end
            end
            TS_CALC:
            begin
                if (angle_done)
                begin
                    state_next = TS_PUT;
                end
            end
            TS_PUT:
            begin
                if (put_fire)
                begin
                    state_next = TS_IDLE;
                end
            end
            default:
            begin
                state_next = TS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = (state_reg != TS_IDLE);
        lane_start = 1'b0;
        put_fire   = 1'b0;
        case (state_reg)
            TS_IDLE:
            begin
                lane_start = sample_fire;
            end
            TS_PUT:
            begin
                put_fire = !out_valid_reg || !out_stall;
            end
            default:
            begin
                put_fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= TS_IDLE;
            prev_count_reg <= '0;
            position_reg   <= '0;
            angle_reg      <= '0;
            speed_reg      <= '0;
            dir_reg        <= DIR_STILL;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (sample_fire)
            begin
                prev_count_reg <= now_count;
                position_reg   <= pos_new;
                dir_reg        <= delta_neg ? DIR_REV : ((diff != '0) ? DIR_FWD : DIR_STILL);
            end
            else if (in_fire && hstat.clear)
            begin
                prev_count_reg <= '0;
                position_reg   <= '0;
                angle_reg      <= '0;
                speed_reg      <= '0;
                dir_reg        <= DIR_STILL;
            end
            if ((state_reg == TS_CALC) && angle_done)
            begin
                angle_reg <= angle_res;
                speed_reg <= speed_res;
            end
            if (put_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // staging and output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            motor_stage_reg <= hstat.motor;
            clear_stage_reg <= hstat.clear;
        end
        if (put_fire)
        begin
            pos_out_reg   <= signed'(position_reg);
            angle_out_reg <= angle_reg;
            dir_out_reg   <= dir_reg;
            speed_out_reg <= speed_reg;
            phase_out_reg <= hstat.phase;
            motor_out_reg <= motor_stage_reg;
            clear_out_reg <= clear_stage_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign position      = pos_out_reg;
    assign angle_q8      = angle_out_reg;
    assign direction     = signed'(dir_out_reg);
    assign speed_q8      = speed_out_reg;
    assign homing_status = phase_out_reg;
    assign motor_command = motor_out_reg;
    assign counter_clear = clear_out_reg;

    esph_homing u_homing (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (in_fire && (kind != KIND_SAMPLE)),
        .kind       (kind_t'(kind)),
        .limit_ms   (tmo_reg),
        .stat       (hstat)
    );

    esph_scale #(
        .A_W   (POS_W),
        .B_W   (MUL_W),
        .SHIFT (Q_SHIFT),
        .DIV_W (CPR_W),
        .OUT_W (ANGLE_W)
    ) u_angle (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (lane_start),
        .a_mag   (pos_mag),
        .b       (MUL_W'(ANGLE_FACTOR)),
        .neg     (pos_new[POS_W-1]),
        .divisor (div_cpr),
        .done    (angle_done),
        .result  (angle_res)
    );

    esph_scale #(
        .A_W   (POS_W),
        .B_W   (MUL_W),
        .SHIFT (Q_SHIFT),
        .DIV_W (CPR_W),
        .OUT_W (SPEED_W)
    ) u_speed (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (lane_start),
        .a_mag   (POS_W'(diff_mag)),
        .b       (speed_factor),
        .neg     (delta_neg),
        .divisor (div_cpr),
        .done    (speed_done),
        .result  (speed_res)
    );

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        angle_done == speed_done)
        else $error("angle and speed lanes out of step");

    a_lane_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        angle_done |-> (state_reg == TS_CALC))
        else $error("lane result arrived outside calculation");

    a_out_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == TS_PUT))
        else $error("result beat raised outside the put state");

endmodule

`default_nettype wire
